### src/dmsd_pkg.sv
package dmsd_pkg;

  localparam int TARGET_W = 20;
  localparam int LEVEL_W  = 19;
  localparam int LIMIT_W  = 18;
  localparam int MAG_W    = 18;
  localparam int DAC_W    = 12;
  localparam int PROD_W   = MAG_W + DAC_W;
  localparam int RECIP_SHIFT = PROD_W + MAG_W;
  localparam int RECIP_W  = 31;

  localparam logic [LIMIT_W-1:0] VMAX     = 18'd216269;
  localparam logic [LIMIT_W-1:0] REV_STEP = 18'd1638;
  localparam logic [MAG_W-1:0]   ENA_MIN  = 18'd3;
  localparam logic [DAC_W-1:0]   DAC_FULL_SCALE = 12'd4095;

  // Rounded-up reciprocal of VMAX; exact floor division for any product below 2^PROD_W.
  localparam logic [RECIP_W-1:0] DAC_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(VMAX) - 64'd1) / 64'(VMAX));

  typedef logic signed [TARGET_W-1:0] target_t;
  typedef logic signed [LEVEL_W-1:0]  level_t;
  typedef logic [LIMIT_W-1:0]         limit_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [DAC_W-1:0]           dac_t;
  typedef logic [PROD_W-1:0]          prod_t;

  typedef enum logic {
    CFG_STEP_LEFT  = 1'b0,
    CFG_STEP_RIGHT = 1'b1
  } cfg_index_t;

  function automatic mag_t level_mag(input level_t level);
    level_t neg;
    neg = -level;
    return level[LEVEL_W-1] ? neg[MAG_W-1:0] : level[MAG_W-1:0];
  endfunction

endpackage

### src/dmsd_slew.sv
module dmsd_slew
  import dmsd_pkg::*;
(
  input  level_t  held,
  input  target_t target,
  input  limit_t  limit,
  output level_t  level_next
);

  logic                 reversal;
  limit_t               step;
  logic signed [21:0]   diff;
  logic signed [21:0]   stp;
  logic signed [21:0]   held_x;
  logic signed [21:0]   cand;
  logic signed [21:0]   vmax_x;

  always_comb begin
    reversal = ((target > 0) && (held < 0)) || ((target < 0) && (held > 0));
    if (limit == '0) begin
      step = VMAX;
    end else if (reversal) begin
      step = REV_STEP;
    end else begin
      step = limit;
    end
    stp    = signed'({4'b0, step});
    vmax_x = signed'({4'b0, VMAX});
    held_x = 22'(held);
    diff   = 22'(target) - held_x;
    if (diff > stp) begin
      cand = held_x + stp;
    end else if (diff < -stp) begin
      cand = held_x - stp;
    end else begin
      cand = 22'(target);
    end
    if (cand > vmax_x) begin
      level_next = LEVEL_W'(vmax_x);
    end else if (cand < -vmax_x) begin
      level_next = LEVEL_W'(-vmax_x);
    end else begin
      level_next = LEVEL_W'(cand);
    end
  end

endmodule

### src/dmsd_dac.sv
module dmsd_dac
  import dmsd_pkg::*;
(
  input  logic   clk,
  input  logic   load,
  input  level_t level,
  output dac_t   dac
);

  prod_t                       prod;
  mag_t                        mag;
  logic [PROD_W+RECIP_W-1:0]   scaled;

  assign mag = level_mag(level);

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {mag, {DAC_W{1'b0}}} - PROD_W'(mag);
    end
  end

  assign scaled = (PROD_W+RECIP_W)'(prod) * (PROD_W+RECIP_W)'(DAC_RECIP);
  assign dac    = scaled[RECIP_SHIFT +: DAC_W];

endmodule

### src/dual_motor_slew_limited_drive_top.sv
// Dual slew-limited motor drive. Each request carries a left and a right target voltage in
// signed Q16 volts; each side's held level moves toward its target by at most its step limit
// (1638 on a sign reversal, a full 3.3 V step when the limit register is zero), is clamped to
// +-3.3 V, and is turned into a level, enable, direction and 12-bit converter code. One request
// is accepted every cycle while the result is taken or none is waiting; the pipeline stalls as a
// whole while the result is not taken. A request passes the target, held-level, level and output
// registers. The rate is set by the held-level feedback in the slew stage.
module dual_motor_slew_limited_drive_top
  import dmsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  limit_t     cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  target_t    target_left,
  input  target_t    target_right,
  output logic       out_valid,
  input  logic       out_ready,
  output level_t     level_left,
  output level_t     level_right,
  output logic       enable_left,
  output logic       enable_right,
  output logic       dir_left,
  output logic       dir_right,
  output dac_t       dac_left,
  output dac_t       dac_right
);

  logic    advance;
  limit_t  step_limit_left;
  limit_t  step_limit_right;
  logic    s1_valid;
  target_t tgt_left;
  target_t tgt_right;
  logic    s2_valid;
  level_t  held_left;
  level_t  held_right;
  level_t  held_left_next;
  level_t  held_right_next;
  logic    s3_valid;
  level_t  lvl_left;
  level_t  lvl_right;
  dac_t    code_left;
  dac_t    code_right;
  mag_t    mag_left;
  mag_t    mag_right;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit_left  <= '0;
      step_limit_right <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_STEP_LEFT:  step_limit_left  <= cfg_data;
        CFG_STEP_RIGHT: step_limit_right <= cfg_data;
        default: ;
      endcase
    end
  end

  dmsd_slew u_slew_left (
    .held       (held_left),
    .target     (tgt_left),
    .limit      (step_limit_left),
    .level_next (held_left_next)
  );

  dmsd_slew u_slew_right (
    .held       (held_right),
    .target     (tgt_right),
    .limit      (step_limit_right),
    .level_next (held_right_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      out_valid  <= 1'b0;
      held_left  <= '0;
      held_right <= '0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
      if (s1_valid) begin
        held_left  <= held_left_next;
        held_right <= held_right_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tgt_left     <= target_left;
      tgt_right    <= target_right;
      lvl_left     <= held_left;
      lvl_right    <= held_right;
      level_left   <= lvl_left;
      level_right  <= lvl_right;
      enable_left  <= (mag_left >= ENA_MIN);
      enable_right <= (mag_right >= ENA_MIN);
      dir_left     <= lvl_left[LEVEL_W-1] || (lvl_left == '0);
      dir_right    <= !lvl_right[LEVEL_W-1];
      dac_left     <= code_left;
      dac_right    <= code_right;
    end
  end

  assign mag_left  = level_mag(lvl_left);
  assign mag_right = level_mag(lvl_right);

  dmsd_dac u_dac_left (
    .clk   (clk),
    .load  (advance),
    .level (held_left),
    .dac   (code_left)
  );

  dmsd_dac u_dac_right (
    .clk   (clk),
    .load  (advance),
    .level (held_right),
    .dac   (code_right)
  );

  a_held_in_range: assert property (@(posedge clk) disable iff (rst)
    (held_left <= signed'({1'b0, VMAX})) && (held_left >= -signed'({1'b0, VMAX})))
    else $error("left held level outside the clamp range");

  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !(advance && s1_valid) |=> $stable(held_left) && $stable(held_right))
    else $error("held level changed without a request in the slew stage");

  a_full_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && (level_left == signed'({1'b0, VMAX})) |-> (dac_left == DAC_FULL_SCALE))
    else $error("full-scale level did not give the full-scale code");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> enable_right || (dac_right == '0))
    else $error("disabled right side with a nonzero converter code");

endmodule
